// ----- src/frame_rate_latency_monitor_assert.svh -----
// Assertion macros shared by the monitor's modules.
`ifndef FRAME_RATE_LATENCY_MONITOR_ASSERT_SVH
`define FRAME_RATE_LATENCY_MONITOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FRLM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frlm assertion failed");

// Next-cycle implication, checked outside reset.
`define FRLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frlm assertion failed");

`endif

// ----- src/frlm_pkg.sv -----
`default_nettype none
package frlm_pkg;
    localparam int TimeW     = 48;
    localparam int FifoDepth = 16;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int FillW     = PtrW + 1;
    localparam int SumW      = 48;
    localparam int AvgLatW   = 40;
    localparam int WeightW   = 17;
    localparam int DivW      = 48;
    localparam int DivSteps  = DivW;
    localparam int DivCntW   = $clog2(DivSteps);
    localparam int ProdW     = WeightW + AvgLatW;
    localparam int AccW      = ProdW + 1;
    localparam int CfgIdxW   = 1;
    localparam int CfgDataW  = 32;

    localparam logic [WeightW-1:0] WeightOne = 17'h10000;
    localparam logic [WeightW-1:0] SmoothRst = 17'd6554;
    localparam logic [31:0]        TickRst   = 32'd100000000;
    localparam logic [31:0]        U32Max    = 32'hFFFF_FFFF;
    localparam logic [SumW-1:0]    SumMax    = {SumW{1'b1}};
    localparam logic [AccW-1:0]    RoundHalf = AccW'(32768);

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DONE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_SMOOTH = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_TICK   = 1'b1;

    typedef struct packed {
        logic push;
        logic clear;
        logic latch;
        logic prep;
        logic div_load;
        logic div_step;
        logic mul_a;
        logic mul_b;
        logic ema_fin;
        logic sel_lat;
    } t_cmd;

    typedef struct packed {
        logic has_rate;
        logic has_lat;
        logic iv_zero;
        logic div_last;
    } t_sts;
endpackage
`default_nettype wire

// ----- src/frlm_ctrl.sv -----
`default_nettype none
`include "frame_rate_latency_monitor_assert.svh"
module frlm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_command,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire frlm_pkg::t_sts i_sts,
    output frlm_pkg::t_cmd     o_cmd
);
    import frlm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MR1  = 4'd4;
    localparam logic [3:0] S_MR2  = 4'd5;
    localparam logic [3:0] S_MR3  = 4'd6;
    localparam logic [3:0] S_ML1  = 4'd7;
    localparam logic [3:0] S_ML2  = 4'd8;
    localparam logic [3:0] S_ML3  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_START: o_cmd.push = 1'b1;
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        CMD_DONE: begin
                            o_cmd.latch = 1'b1;
                            n_state = S_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.div_load = 1'b1;
                if (!i_sts.has_rate) begin
                    n_state = i_sts.has_lat ? S_ML1 : S_OUT;
                end else if (i_sts.iv_zero) begin
                    n_state = S_MR1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MR1;
                end
            end
            S_MR1: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MR2;
            end
            S_MR2: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_MR3;
            end
            S_MR3: begin
                o_cmd.ema_fin = 1'b1;
                n_state = i_sts.has_lat ? S_ML1 : S_OUT;
            end
            S_ML1: begin
                o_cmd.mul_a = 1'b1;
                o_cmd.sel_lat = 1'b1;
                n_state = S_ML2;
            end
            S_ML2: begin
                o_cmd.mul_b = 1'b1;
                o_cmd.sel_lat = 1'b1;
                n_state = S_ML3;
            end
            S_ML3: begin
                o_cmd.ema_fin = 1'b1;
                o_cmd.sel_lat = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `FRLM_ASSERT_NEXT(a_out_hold, r_state == S_OUT && i_out_stall, r_state == S_OUT)
    `FRLM_ASSERT_NEXT(a_prep_to_chk, r_state == S_PREP, r_state == S_CHK)
    `FRLM_ASSERT_NEXT(a_div_exit, r_state == S_DIV && i_sts.div_last, r_state == S_MR1)
endmodule
`default_nettype wire

// ----- src/frlm_dp.sv -----
`default_nettype none
module frlm_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire frlm_pkg::t_cmd                  i_cmd,
    output frlm_pkg::t_sts                       o_sts,
    input  wire logic [frlm_pkg::TimeW-1:0]      i_timestamp,
    input  wire logic                            i_cfg_we,
    input  wire logic [frlm_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [frlm_pkg::CfgDataW-1:0]   i_cfg_data,
    output logic [31:0]                          o_frames_counted,
    output logic                                 o_rate_valid,
    output logic [31:0]                          o_frame_interval,
    output logic [frlm_pkg::SumW-1:0]            o_interval_total,
    output logic [31:0]                          o_current_rate,
    output logic [31:0]                          o_smoothed_rate,
    output logic                                 o_latency_valid,
    output logic [31:0]                          o_frame_latency,
    output logic [frlm_pkg::SumW-1:0]            o_latency_total,
    output logic [frlm_pkg::AvgLatW-1:0]         o_smoothed_latency,
    output logic                                 o_start_overflow
);
    import frlm_pkg::*;

    logic [WeightW-1:0] r_sf;
    logic [31:0]        r_tick;

    logic [TimeW-1:0]   r_mem [FifoDepth];
    logic [TimeW-1:0]   r_rd_data;
    logic [PtrW-1:0]    r_rd_ptr;
    logic [FillW-1:0]   r_fill;
    logic               r_ovf;

    logic [TimeW-1:0]   r_t, r_prev;
    logic [31:0]        r_iv, r_lat, r_rate, r_ravg, r_cnt;
    logic [SumW-1:0]    r_isum, r_lsum;
    logic [AvgLatW-1:0] r_lavg;
    logic               r_has_rate, r_has_lat;

    logic [DivW-1:0]    r_dq;
    logic [32:0]        r_rem;
    logic [DivCntW-1:0] r_dcnt;
    logic [ProdW-1:0]   r_prod;
    logic [AccW-1:0]    r_acc;

    logic [PtrW-1:0]    w_wptr;
    logic [TimeW-1:0]   w_idiff, w_ldiff;
    logic [SumW:0]      w_isum, w_lsum;
    logic [32:0]        w_rem_sh, w_rem_sub;
    logic [31:0]        w_rate;
    logic [WeightW-1:0] w_wt, w_inv, w_ma;
    logic [AvgLatW-1:0] w_mb;
    logic [AccW-1:0]    w_sum;

    assign w_wptr  = r_rd_ptr + r_fill[PtrW-1:0];
    assign w_idiff = r_t - r_prev;
    assign w_ldiff = r_t - r_rd_data;
    assign w_isum  = {1'b0, r_isum} + {1'b0, w_idiff};
    assign w_lsum  = {1'b0, r_lsum} + {1'b0, w_ldiff};

    assign w_rem_sh  = {r_rem[31:0], r_dq[DivW-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_iv};

    assign w_rate = (r_iv == '0 || r_dq[DivW-1:32] != '0) ? U32Max : r_dq[31:0];

    assign w_wt  = (r_sf > WeightOne) ? WeightOne : r_sf;
    assign w_inv = WeightOne - w_wt;
    assign w_ma  = i_cmd.mul_a ? w_inv : w_wt;
    always_comb begin
        if (i_cmd.sel_lat) begin
            w_mb = i_cmd.mul_a ? r_lavg : {r_lat, 8'b0};
        end else begin
            w_mb = {8'b0, (i_cmd.mul_a ? r_ravg : w_rate)};
        end
    end
    assign w_sum = r_acc + {1'b0, r_prod};

    // Configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf     <= SmoothRst;
            r_tick   <= TickRst;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_prev   <= '0;
            r_isum   <= '0;
            r_lsum   <= '0;
            r_cnt    <= '0;
            r_ravg   <= '0;
            r_lavg   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SMOOTH: r_sf <= i_cfg_data[WeightW-1:0];
                    REG_TICK:   r_tick <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                if (r_fill == FillW'(FifoDepth)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_isum <= '0;
                r_lsum <= '0;
                r_cnt  <= '0;
                r_ravg <= '0;
                r_lavg <= '0;
            end
            if (i_cmd.prep) begin
                r_prev <= r_t;
                if (r_cnt == '0) begin
                    r_isum <= '0;
                end else begin
                    r_isum <= w_isum[SumW] ? SumMax : w_isum[SumW-1:0];
                end
                if (r_fill != '0) begin
                    r_lsum   <= w_lsum[SumW] ? SumMax : w_lsum[SumW-1:0];
                    r_cnt    <= (r_cnt == U32Max) ? r_cnt : r_cnt + 1'b1;
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                    r_fill   <= r_fill - 1'b1;
                end
            end
            if (i_cmd.ema_fin) begin
                if (i_cmd.sel_lat) begin
                    r_lavg <= w_sum[AvgLatW+15:16];
                end else begin
                    r_ravg <= w_sum[47:16];
                end
            end
        end
    end

    // Start-time store and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_fill != FillW'(FifoDepth)) begin
            r_mem[w_wptr] <= i_timestamp;
        end
        r_rd_data <= r_mem[r_rd_ptr];
        if (i_cmd.latch) begin
            r_t <= i_timestamp;
        end
        if (i_cmd.prep) begin
            r_has_rate <= (r_cnt != '0);
            r_has_lat  <= (r_fill != '0);
            r_iv  <= (w_idiff[TimeW-1:32] != '0) ? U32Max : w_idiff[31:0];
            r_lat <= (w_ldiff[TimeW-1:32] != '0) ? U32Max : w_ldiff[31:0];
        end
        if (i_cmd.div_load) begin
            r_dq   <= {r_tick, 16'b0};
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_rem_sub[32]) begin
                r_rem <= w_rem_sub;
                r_dq  <= {r_dq[DivW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_dq  <= {r_dq[DivW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.mul_a || i_cmd.mul_b) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.mul_a && !i_cmd.sel_lat) begin
            r_rate <= w_rate;
        end
        if (i_cmd.mul_b) begin
            r_acc <= {1'b0, r_prod} + RoundHalf;
        end
    end

    assign o_sts.has_rate = r_has_rate;
    assign o_sts.has_lat  = r_has_lat;
    assign o_sts.iv_zero  = (r_iv == '0);
    assign o_sts.div_last = (r_dcnt == DivCntW'(DivSteps - 1));

    assign o_frames_counted   = r_cnt;
    assign o_rate_valid       = r_has_rate;
    assign o_frame_interval   = r_has_rate ? r_iv : '0;
    assign o_interval_total   = r_has_rate ? r_isum : '0;
    assign o_current_rate     = r_has_rate ? r_rate : '0;
    assign o_smoothed_rate    = r_has_rate ? r_ravg : '0;
    assign o_latency_valid    = r_has_lat;
    assign o_frame_latency    = r_has_lat ? r_lat : '0;
    assign o_latency_total    = r_has_lat ? r_lsum : '0;
    assign o_smoothed_latency = r_has_lat ? r_lavg : '0;
    assign o_start_overflow   = r_ovf;
endmodule
`default_nettype wire

// ----- src/frame_rate_latency_monitor.sv -----
// Frame rate and latency monitor. A start event pushes its timestamp into a
// sixteen-entry start-time store (a full store drops the time and sets the
// sticky overflow flag); a clear event resets the statistics. A done event
// produces one result transfer: when there is a nonzero interval, a 48-step
// restoring divider forms the rate one quotient bit per cycle, followed by up
// to two moving-average updates, rate and latency, on one shared 17 by 40 bit
// multiplier. Only one event is worked on at a time, and the result is held on
// the output until it is taken.
`default_nettype none
module frame_rate_latency_monitor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_command,
    input  wire logic [frlm_pkg::TimeW-1:0]      i_timestamp,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [31:0]                          o_frames_counted,
    output logic                                 o_rate_valid,
    output logic [31:0]                          o_frame_interval,
    output logic [frlm_pkg::SumW-1:0]            o_interval_total,
    output logic [31:0]                          o_current_rate,
    output logic [31:0]                          o_smoothed_rate,
    output logic                                 o_latency_valid,
    output logic [31:0]                          o_frame_latency,
    output logic [frlm_pkg::SumW-1:0]            o_latency_total,
    output logic [frlm_pkg::AvgLatW-1:0]         o_smoothed_latency,
    output logic                                 o_start_overflow,
    input  wire logic                            i_cfg_we,
    input  wire logic [frlm_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [frlm_pkg::CfgDataW-1:0]   i_cfg_data
);
    import frlm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences each done event through its steps.
    frlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the statistics, the start-time store and the units.
    frlm_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_timestamp        (i_timestamp),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_frames_counted   (o_frames_counted),
        .o_rate_valid       (o_rate_valid),
        .o_frame_interval   (o_frame_interval),
        .o_interval_total   (o_interval_total),
        .o_current_rate     (o_current_rate),
        .o_smoothed_rate    (o_smoothed_rate),
        .o_latency_valid    (o_latency_valid),
        .o_frame_latency    (o_frame_latency),
        .o_latency_total    (o_latency_total),
        .o_smoothed_latency (o_smoothed_latency),
        .o_start_overflow   (o_start_overflow)
    );
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import frlm_pkg::*;

    // The run is stopped here if the block stops making progress.
    localparam int CycleLimit = 3000000;
    // Cycles allowed for a done event to finish before the block is treated as idle.
    localparam int DrainCycles = 120;
    // The one command code that the block ignores.
    localparam logic [1:0] CmdUnused = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_command;
    logic [TimeW-1:0]     i_timestamp;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [31:0]          o_frames_counted;
    logic                 o_rate_valid;
    logic [31:0]          o_frame_interval;
    logic [SumW-1:0]      o_interval_total;
    logic [31:0]          o_current_rate;
    logic [31:0]          o_smoothed_rate;
    logic                 o_latency_valid;
    logic [31:0]          o_frame_latency;
    logic [SumW-1:0]      o_latency_total;
    logic [AvgLatW-1:0]   o_smoothed_latency;
    logic                 o_start_overflow;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_index;
    logic [CfgDataW-1:0]  i_cfg_data;

    frame_rate_latency_monitor i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_timestamp        (i_timestamp),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frames_counted   (o_frames_counted),
        .o_rate_valid       (o_rate_valid),
        .o_frame_interval   (o_frame_interval),
        .o_interval_total   (o_interval_total),
        .o_current_rate     (o_current_rate),
        .o_smoothed_rate    (o_smoothed_rate),
        .o_latency_valid    (o_latency_valid),
        .o_frame_latency    (o_frame_latency),
        .o_latency_total    (o_latency_total),
        .o_smoothed_latency (o_smoothed_latency),
        .o_start_overflow   (o_start_overflow),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // One frame statistics report as the block should produce it.
    typedef struct {
        logic [31:0]        frames;
        logic               rate_ok;
        logic [31:0]        interval;
        logic [SumW-1:0]    interval_sum;
        logic [31:0]        rate;
        logic [31:0]        rate_avg;
        logic               lat_ok;
        logic [31:0]        latency;
        logic [SumW-1:0]    latency_sum;
        logic [AvgLatW-1:0] latency_avg;
        logic               overflow;
    } frame_report_t;

    frame_report_t report_q[$];

    // The testbench's own copy of the monitor state and its registers.
    logic [WeightW-1:0] m_weight;
    logic [31:0]        m_tick_rate;
    logic [TimeW-1:0]   m_starts [FifoDepth];
    int                 m_fill;
    int                 m_rd_ptr;
    logic [TimeW-1:0]   m_last_done;
    logic [63:0]        m_interval_sum;
    logic [63:0]        m_latency_sum;
    logic [63:0]        m_frames;
    logic [63:0]        m_rate_avg;
    logic [63:0]        m_latency_avg;
    logic               m_overflow;

    int  mismatches;
    int  cycles;
    bit  quiet;       // when set, neither side inserts gaps or stalls
    bit  held;        // input valid has been left high after the last transfer
    logic [TimeW-1:0] now_ts;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, occasionally long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // The output side holds its stall value for a random stretch, then picks again.
    int stall_hold;
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold == 0) begin
            if ($urandom_range(1) == 0) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(8);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= gap_len();
            end
        end else begin
            stall_hold <= stall_hold - 1;
        end
    end

    function automatic logic [63:0] sat32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'(SumMax)) ? 64'(SumMax) : s;
    endfunction

    // Exponential moving average with rounding half up; a weight above one acts as one.
    function automatic logic [63:0] smooth(input logic [63:0] avg, input logic [63:0] cur);
        logic [63:0] w;
        w = (m_weight > WeightOne) ? 64'(WeightOne) : 64'(m_weight);
        return ((64'd65536 - w) * avg + w * cur + 64'd32768) >> 16;
    endfunction

    task automatic reset_model();
        m_weight       = SmoothRst;
        m_tick_rate    = TickRst;
        m_fill         = 0;
        m_rd_ptr       = 0;
        m_last_done    = '0;
        m_interval_sum = 0;
        m_latency_sum  = 0;
        m_frames       = 0;
        m_rate_avg     = 0;
        m_latency_avg  = 0;
        m_overflow     = 1'b0;
    endtask

    // Updates the state for one accepted event and queues the report that a done
    // event must produce.
    task automatic predict_event(input logic [1:0] cmd, input logic [TimeW-1:0] ts);
        frame_report_t rep;
        logic [TimeW-1:0] diff;
        logic [63:0] iv;
        logic [63:0] rt;
        logic [63:0] lat;
        if (cmd == CMD_START) begin
            if (m_fill >= FifoDepth) begin
                m_overflow = 1'b1;
            end else begin
                m_starts[PtrW'((m_rd_ptr + m_fill) % FifoDepth)] = ts;
                m_fill++;
            end
        end else if (cmd == CMD_CLEAR) begin
            m_interval_sum = 0;
            m_latency_sum  = 0;
            m_frames       = 0;
            m_rate_avg     = 0;
            m_latency_avg  = 0;
        end else if (cmd == CMD_DONE) begin
            rep = '{default: '0};
            if (m_frames == 0) begin
                // Until a frame has been matched, a done event only marks the time for the rate.
                m_last_done    = ts;
                m_interval_sum = 0;
            end else begin
                diff        = ts - m_last_done;
                iv          = sat32(64'(diff));
                m_last_done = ts;
                if (iv == 0) rt = 64'hFFFF_FFFF;
                else         rt = sat32((64'(m_tick_rate) << 16) / iv);
                m_rate_avg     = smooth(m_rate_avg, rt) & 64'hFFFF_FFFF;
                m_interval_sum = sum_sat(m_interval_sum, 64'(diff));
                rep.rate_ok      = 1'b1;
                rep.interval     = iv[31:0];
                rep.interval_sum = m_interval_sum[SumW-1:0];
                rep.rate         = rt[31:0];
                rep.rate_avg     = m_rate_avg[31:0];
            end
            if (m_fill > 0) begin
                diff          = ts - m_starts[PtrW'(m_rd_ptr)];
                lat           = sat32(64'(diff));
                m_latency_sum = sum_sat(m_latency_sum, 64'(diff));
                if (m_frames < 64'hFFFF_FFFF) m_frames++;
                m_rd_ptr      = (m_rd_ptr + 1) % FifoDepth;
                m_fill--;
                m_latency_avg = smooth(m_latency_avg, lat << 8) & 64'hFF_FFFF_FFFF;
                rep.lat_ok      = 1'b1;
                rep.latency     = lat[31:0];
                rep.latency_sum = m_latency_sum[SumW-1:0];
                rep.latency_avg = m_latency_avg[AvgLatW-1:0];
            end
            rep.frames   = m_frames[31:0];
            rep.overflow = m_overflow;
            report_q.push_back(rep);
        end
    endtask

    function automatic bit field_ok(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
        if (want === got) return 1'b1;
        if (mismatches < 10)
            $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        mismatches++;
        return 1'b0;
    endfunction

    // Every report transfer is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        frame_report_t w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (report_q.size() == 0) begin
                if (mismatches < 10) $display("report transfer with nothing expected");
                mismatches++;
            end else begin
                w = report_q.pop_front();
                void'(field_ok("frames_counted", 64'(w.frames), 64'(o_frames_counted)));
                void'(field_ok("rate_valid", 64'(w.rate_ok), 64'(o_rate_valid)));
                void'(field_ok("frame_interval", 64'(w.interval), 64'(o_frame_interval)));
                void'(field_ok("interval_total", 64'(w.interval_sum),
                               64'(o_interval_total)));
                void'(field_ok("current_rate", 64'(w.rate), 64'(o_current_rate)));
                void'(field_ok("smoothed_rate", 64'(w.rate_avg), 64'(o_smoothed_rate)));
                void'(field_ok("latency_valid", 64'(w.lat_ok), 64'(o_latency_valid)));
                void'(field_ok("frame_latency", 64'(w.latency), 64'(o_frame_latency)));
                void'(field_ok("latency_total", 64'(w.latency_sum), 64'(o_latency_total)));
                void'(field_ok("smoothed_latency", 64'(w.latency_avg),
                               64'(o_smoothed_latency)));
                void'(field_ok("start_overflow", 64'(w.overflow), 64'(o_start_overflow)));
            end
        end
    end

    // Presents one event and returns once it has been transferred. Valid is left
    // high when no gap follows, so the next event can be presented straight away.
    task automatic send_event(input logic [1:0] cmd, input logic [TimeW-1:0] ts);
        int g;
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_timestamp <= ts;
        held = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_event(cmd, ts);
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            held = 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Waits for every outstanding report, then for the block to finish any
    // event that produces none.
    task automatic wait_idle();
        if (held) begin
            i_in_valid <= 1'b0;
            held = 1'b0;
        end
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SMOOTH) m_weight    = val[WeightW-1:0];
        else                   m_tick_rate = val;
    endtask

    // Short directed pass over the corner cases.
    task automatic test_directed();
        int k;
        quiet = 1'b1;
        send_event(CMD_START, '0);
        send_event(CMD_DONE, 48'd5);               // first done marks the time, no rate yet
        send_event(CMD_START, {TimeW{1'b1}});
        send_event(CMD_DONE, 48'd5);               // same time again: zero interval
        send_event(CMD_DONE, 48'd3);               // wraps; store empty, no latency
        send_event(CMD_CLEAR, 48'h5555_5555_5555);
        send_event(CmdUnused, 48'hAAAA_AAAA_AAAA); // unused code, ignored
        send_event(CMD_DONE, 48'h1234);            // count is zero again after clear
        // Seventeen starts overflow the sixteen-entry store.
        for (k = 0; k < 17; k++) send_event(CMD_START, 48'(k) * 48'h0F0F_0F0F_0F0F);
        send_event(CMD_DONE, {TimeW{1'b1}});
        wait_idle();
        quiet = 1'b0;
    endtask

    function automatic logic [TimeW-1:0] next_time();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return now_ts;
        if (r < 80) return now_ts + 48'($urandom_range(4096));
        if (r < 95) return now_ts + 48'($urandom);
        return TimeW'({$urandom, $urandom});
    endfunction

    // Random traffic, mostly matched start and done pairs.
    task automatic test_random(input int n);
        int sent;
        int r;
        int k;
        int burst;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 60) begin
                now_ts = next_time();
                send_event(CMD_START, now_ts);
                now_ts = next_time();
                send_event(CMD_DONE, now_ts);
                sent += 2;
            end else if (r < 75) begin
                now_ts = next_time();
                send_event(CMD_DONE, now_ts);
                sent++;
            end else if (r < 85) begin
                burst = $urandom_range(18, 1);
                for (k = 0; k < burst; k++) begin
                    now_ts = next_time();
                    send_event(CMD_START, now_ts);
                end
                sent += burst;
            end else if (r < 92) begin
                send_event(CMD_CLEAR, TimeW'({$urandom, $urandom}));
                sent++;
            end else if (r < 96) begin
                send_event(CmdUnused, TimeW'({$urandom, $urandom}));
            end else begin
                send_event(2'($urandom_range(2)), TimeW'({$urandom, $urandom}));
                sent++;
            end
            if ($urandom_range(49) == 0) quiet = !quiet;
        end
        quiet = 1'b0;
        wait_idle();
    endtask

    // Several register settings, the extremes among them, each with random traffic.
    task automatic test_settings();
        write_reg(REG_SMOOTH, 32'd0);
        write_reg(REG_TICK, 32'd1);
        test_random(120);
        write_reg(REG_SMOOTH, 32'(WeightOne));
        write_reg(REG_TICK, 32'hFFFF_FFFF);
        test_random(120);
        write_reg(REG_SMOOTH, 32'h1_FFFF);         // weight above one
        write_reg(REG_TICK, 32'd60);
        test_random(120);
        write_reg(REG_SMOOTH, 32'd1);
        write_reg(REG_TICK, $urandom);
        test_random(120);
        write_reg(REG_SMOOTH, 32'(SmoothRst));
        write_reg(REG_TICK, TickRst);
        test_random(120);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_START;
        i_timestamp = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_SMOOTH;
        i_cfg_data  = '0;
        mismatches  = 0;
        cycles      = 0;
        quiet       = 1'b0;
        held        = 1'b0;
        now_ts      = '0;
        stall_hold  = 0;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(240);
        test_settings();

        wait_idle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
